@@ hdl/text_console_writer_macros.svh @@
// Assertion macros for the text console writer.
`ifndef TEXT_CONSOLE_WRITER_MACROS_SVH
`define TEXT_CONSOLE_WRITER_MACROS_SVH

`ifndef NO_ASSERTIONS
// Property must hold at every clock edge outside reset.
`define TCW_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Condition must never be seen outside reset.
`define TCW_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define TCW_ASSERT(lbl, prop, msg)
`define TCW_NEVER(lbl, cond, msg)
`endif

`endif

@@ hdl/tcw_pkg.sv @@
// Shared constants for the text console writer.
`timescale 1ns / 1ps

package tcw_pkg;

    localparam int CELL_W = 16;

    // operation codes
    localparam logic [1:0] OP_PUT   = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    // control characters
    localparam logic [7:0] CH_BS  = 8'h08;
    localparam logic [7:0] CH_TAB = 8'h09;
    localparam logic [7:0] CH_LF  = 8'h0A;
    localparam logic [7:0] CH_CR  = 8'h0D;

    localparam logic [7:0] BLANK_CHAR = 8'h20;
    localparam logic [7:0] RESET_ATTR = 8'h07;
    localparam int         TAB_STEP   = 8;

    // register index, taken from paddr[2]
    localparam logic REG_TEXT_ATTR = 1'b0;

endpackage

@@ hdl/tcw_ram.sv @@
// Single-port-write, registered-read cell store for the text console writer.
`timescale 1ns / 1ps

module tcw_ram #(
    parameter int DEPTH = 2000,
    parameter int AW    = 11,
    parameter int DW    = 16
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);

    logic [DW-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ hdl/text_console_writer.sv @@
// Text console writer top level: sequencer, cursor tracking, config port.
//
// Usage:
//  - Input stream s_*: one transaction per command (put character, read cell,
//    clear screen). s_tready is high only while the block is idle.
//  - Output stream m_*: exactly one transaction per command, carrying the cursor
//    after the command, the read cell (0 for non-read commands) and a scroll flag.
//  - APB port: register 0 (byte address 0) is the text attribute, reset 0x07.
//    Write it only while no command is in flight.
// A put steps through S_EXEC, S_FIX and S_FIN, a read through S_EXEC, S_RDW
// and S_FIN, an unused op code or a read past the end through S_EXEC and S_FIN.
// A put that runs off the last cell scrolls: it copies each row below the first
// up one row, alternating a read and a write through the store's single write
// port, then blanks the last row. Clear blanks every cell (one cell write per cycle).
// A new command is taken only after the last one has left S_FIN; the store's
// single write port and the one shared address/cursor adder make the steps serial.
// After reset the block blanks the whole store (all COLUMNS*ROWS cells, 2000 at
// the default size) with s_tready low; APB writes are taken during that pass.
// A stalled receiver holds the result in the output register; the next command
// is still accepted and runs until its own result is ready, then waits.
`timescale 1ns / 1ps
`include "text_console_writer_macros.svh"

module text_console_writer
    import tcw_pkg::*;
#(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic        clk,
    input  logic        rst_n,
    // APB configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // command stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,  // op[1:0], char_code[9:2], cell_index[20:10], zero
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata   // cursor_pos[10:0], cell_data[26:11], scrolled[27], zero
);

    localparam int CELLS = COLUMNS * ROWS;
    localparam int AW    = $clog2(CELLS);
    localparam int CW    = AW + 1;   // cursor may briefly run past the last cell

    localparam logic [CW-1:0] CELLS_C   = CW'(CELLS);
    localparam logic [CW-1:0] COLS_C    = CW'(COLUMNS);
    localparam logic [CW-1:0] COLS_NEG  = ~COLS_C + CW'(1);
    localparam logic [CW-1:0] LAST_C    = CW'((ROWS - 1) * COLUMNS);
    localparam logic [CW-1:0] ONE_C     = CW'(1);
    localparam logic [CW-1:0] TAB_C     = CW'(TAB_STEP);
    localparam logic [CW-1:0] TAB_MASK  = ~CW'(TAB_STEP - 1);
    localparam logic [AW-1:0] PTR_END   = AW'(CELLS - 1);
    localparam logic [AW-1:0] COPY_END  = AW'((ROWS - 1) * COLUMNS - 1);

    localparam logic [CELL_W-1:0] RESET_BLANK = {RESET_ATTR, BLANK_CHAR};

    // sequencer states
    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_EXEC    = 3'd1;
    localparam logic [2:0] S_FIX     = 3'd2;
    localparam logic [2:0] S_RDW     = 3'd3;
    localparam logic [2:0] S_COPY_RD = 3'd4;
    localparam logic [2:0] S_COPY_WR = 3'd5;
    localparam logic [2:0] S_CLR     = 3'd6;
    localparam logic [2:0] S_FIN     = 3'd7;

    logic [2:0]        state_reg, state_next;
    logic [1:0]        op_reg, op_next;
    logic [7:0]        ch_reg, ch_next;
    logic [10:0]       idx_reg, idx_next;
    logic [CW-1:0]     cur_reg, cur_next;
    logic [CW-1:0]     rb_reg, rb_next;      // start of cursor's row
    logic [CW-1:0]     rbn_reg, rbn_next;    // start of the row after
    logic [AW-1:0]     ptr_reg, ptr_next;    // sweep / copy pointer
    logic [CELL_W-1:0] blank_reg, blank_next;
    logic              boot_reg, boot_next;  // post-reset blanking pass
    logic              moved_reg, moved_next;
    logic              scr_reg, scr_next;
    logic [CELL_W-1:0] data_reg, data_next;
    logic [7:0]        attr_reg, attr_next;

    logic              m_valid_reg, m_valid_next;
    logic [10:0]       out_cur_reg, out_cur_next;
    logic [CELL_W-1:0] out_data_reg, out_data_next;
    logic              out_scr_reg, out_scr_next;

    // shared adder
    logic [CW-1:0] add_a, add_b, sum;

    // store port
    logic              ram_we, ram_re;
    logic [AW-1:0]     ram_waddr, ram_raddr;
    logic [CELL_W-1:0] ram_wdata, ram_rdata;

    logic accept, cfg_wr, fin_load;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = (state_reg == S_IDLE);
    assign fin_load = (state_reg == S_FIN) && (!m_valid_reg || m_tready);

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_TEXT_ATTR);
    assign prdata = (paddr[2] == REG_TEXT_ATTR) ? {24'd0, attr_reg} : 32'd0;
    assign attr_next = cfg_wr ? pwdata[7:0] : attr_reg;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {4'd0, out_scr_reg, out_data_reg, out_cur_reg};

    assign sum = add_a + add_b;

    // operand selection for the shared adder
    always_comb
    begin
        add_a = cur_reg;
        add_b = '0;
        case (state_reg)
            S_EXEC:
            begin
                if (ch_reg == CH_LF)
                begin
                    add_a = rb_reg;
                    add_b = COLS_C;
                end
                else if (ch_reg == CH_CR)
                begin
                    add_a = rb_reg;
                end
                else if (ch_reg == CH_BS)
                begin
                    add_b = '1;
                end
                else if (ch_reg == CH_TAB)
                begin
                    add_b = TAB_C;
                end
                else
                begin
                    add_b = ONE_C;
                end
            end
            S_FIX:
            begin
                if (cur_reg < rb_reg)
                begin
                    add_a = rb_reg;
                    add_b = COLS_NEG;
                end
                else
                begin
                    add_a = rbn_reg;
                    add_b = COLS_C;
                end
            end
            S_COPY_RD:
            begin
                add_a = CW'(ptr_reg);
                add_b = COLS_C;
            end
            S_COPY_WR, S_CLR:
            begin
                add_a = CW'(ptr_reg);
                add_b = ONE_C;
            end
            default:
            begin
                add_a = cur_reg;
                add_b = '0;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        ch_next    = ch_reg;
        idx_next   = idx_reg;
        cur_next   = cur_reg;
        rb_next    = rb_reg;
        rbn_next   = rbn_reg;
        ptr_next   = ptr_reg;
        blank_next = blank_reg;
        boot_next  = boot_reg;
        moved_next = moved_reg;
        scr_next   = scr_reg;
        data_next  = data_reg;
        ram_we     = 1'b0;
        ram_waddr  = ptr_reg;
        ram_wdata  = blank_reg;
        ram_re     = 1'b0;
        ram_raddr  = AW'(idx_reg);

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    op_next    = s_tdata[1:0];
                    ch_next    = s_tdata[9:2];
                    idx_next   = s_tdata[20:10];
                    blank_next = {attr_reg, BLANK_CHAR};
                    scr_next   = 1'b0;
                    data_next  = '0;
                    moved_next = 1'b0;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                case (op_reg)
                    OP_PUT:
                    begin
                        if (ch_reg == CH_TAB)
                        begin
                            cur_next = sum & TAB_MASK;
                        end
                        else if (ch_reg == CH_BS)
                        begin
                            if (cur_reg != '0)
                            begin
                                cur_next   = sum;
                                moved_next = 1'b1;
                            end
                        end
                        else
                        begin
                            cur_next = sum;
                        end
                        if ((ch_reg != CH_TAB) && (ch_reg != CH_BS) &&
                            (ch_reg != CH_LF) && (ch_reg != CH_CR))
                        begin
                            ram_we    = 1'b1;
                            ram_waddr = cur_reg[AW-1:0];
                            ram_wdata = {blank_reg[15:8], ch_reg};
                        end
                        state_next = S_FIX;
                    end
                    OP_READ:
                    begin
                        if (32'(idx_reg) < 32'(CELLS))
                        begin
                            ram_re     = 1'b1;
                            state_next = S_RDW;
                        end
                        else
                        begin
                            state_next = S_FIN;
                        end
                    end
                    OP_CLEAR:
                    begin
                        cur_next   = '0;
                        rb_next    = '0;
                        rbn_next   = COLS_C;
                        ptr_next   = '0;
                        state_next = S_CLR;
                    end
                    default:
                    begin
                        state_next = S_FIN;
                    end
                endcase
            end
            S_FIX:
            begin
                if (moved_reg)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = cur_reg[AW-1:0];
                end
                if (cur_reg >= CELLS_C)
                begin
                    // ran off the screen: scroll up one row
                    scr_next   = 1'b1;
                    cur_next   = LAST_C;
                    rb_next    = LAST_C;
                    rbn_next   = CELLS_C;
                    ptr_next   = '0;
                    state_next = S_COPY_RD;
                end
                else
                begin
                    if (cur_reg < rb_reg)
                    begin
                        rb_next  = sum;
                        rbn_next = rb_reg;
                    end
                    else if (cur_reg >= rbn_reg)
                    begin
                        rb_next  = rbn_reg;
                        rbn_next = sum;
                    end
                    state_next = S_FIN;
                end
            end
            S_RDW:
            begin
                data_next  = ram_rdata;
                state_next = S_FIN;
            end
            S_COPY_RD:
            begin
                ram_re     = 1'b1;
                ram_raddr  = sum[AW-1:0];
                state_next = S_COPY_WR;
            end
            S_COPY_WR:
            begin
                ram_we     = 1'b1;
                ram_wdata  = ram_rdata;
                ptr_next   = sum[AW-1:0];
                state_next = (ptr_reg == COPY_END) ? S_CLR : S_COPY_RD;
            end
            S_CLR:
            begin
                ram_we   = 1'b1;
                ptr_next = sum[AW-1:0];
                if (ptr_reg == PTR_END)
                begin
                    boot_next  = 1'b0;
                    state_next = boot_reg ? S_IDLE : S_FIN;
                end
            end
            S_FIN:
            begin
                if (fin_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // output register
    always_comb
    begin
        m_valid_next  = m_valid_reg;
        out_cur_next  = out_cur_reg;
        out_data_next = out_data_reg;
        out_scr_next  = out_scr_reg;
        if (fin_load)
        begin
            m_valid_next  = 1'b1;
            out_cur_next  = 11'(cur_reg);
            out_data_next = data_reg;
            out_scr_next  = scr_reg;
        end
        else if (m_tready)
        begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLR;
            op_reg      <= OP_PUT;
            cur_reg     <= '0;
            rb_reg      <= '0;
            rbn_reg     <= COLS_C;
            ptr_reg     <= '0;
            blank_reg   <= RESET_BLANK;
            boot_reg    <= 1'b1;
            moved_reg   <= 1'b0;
            scr_reg     <= 1'b0;
            attr_reg    <= RESET_ATTR;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            op_reg      <= op_next;
            cur_reg     <= cur_next;
            rb_reg      <= rb_next;
            rbn_reg     <= rbn_next;
            ptr_reg     <= ptr_next;
            blank_reg   <= blank_next;
            boot_reg    <= boot_next;
            moved_reg   <= moved_next;
            scr_reg     <= scr_next;
            attr_reg    <= attr_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        ch_reg       <= ch_next;
        idx_reg      <= idx_next;
        data_reg     <= data_next;
        out_cur_reg  <= out_cur_next;
        out_data_reg <= out_data_next;
        out_scr_reg  <= out_scr_next;
    end

    tcw_ram #(
        .DEPTH (CELLS),
        .AW    (AW),
        .DW    (CELL_W)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // cursor stays on screen between commands
    `TCW_ASSERT(a_cur_range, (state_reg == S_IDLE) |-> (cur_reg < CELLS_C), "cursor off screen")
    // row tracking brackets the cursor between commands
    `TCW_ASSERT(a_row_track, (state_reg == S_IDLE) |-> (rb_reg <= cur_reg && cur_reg < rbn_reg), "row base lost")
    // the store is only written while a command or the reset pass runs
    `TCW_NEVER(a_idle_write, (state_reg == S_IDLE) && ram_we, "store write while idle")
    // a scroll always leaves the cursor at the start of the last row
    `TCW_ASSERT(a_scroll_cur, (m_valid_reg && out_scr_reg) |-> (out_cur_reg == 11'(LAST_C)), "bad cursor after scroll")

endmodule
